### src/sas_pkg.sv
package sas_pkg;

  // field widths
  localparam int KIND_W      = 4;
  localparam int DT_W        = 24;
  localparam int ANIM_IDX_W  = 4;
  localparam int POS_W       = 6;
  localparam int FRAME_IDX_W = 8;
  localparam int LEN_VAL_W   = 24;
  localparam int SPEED_W     = 16;

  // internal widths
  localparam int LEN_W     = POS_W + 1;
  localparam int ELAPSED_W = 32;
  localparam int FRAC_W    = 16;
  localparam int PROD1_W   = 2 * SPEED_W;
  localparam int PROD2_W   = DT_W + PROD1_W;

  // configuration port
  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 3;
  localparam logic [SPEED_W-1:0] GLOBAL_SPEED_RESET = 16'd256;

  // default sizes
  localparam int DEF_FRAME_COUNT = 256;
  localparam int DEF_ANIM_COUNT  = 16;
  localparam int DEF_SEQ_LEN     = 64;

  typedef enum logic [CFG_ADDR_W-3:0] {
    REG_GLOBAL_SPEED = 1'b0
  } reg_idx_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_TICK      = 4'd0,
    KIND_PLAY      = 4'd1,
    KIND_PAUSE     = 4'd2,
    KIND_RESUME    = 4'd3,
    KIND_REWIND    = 4'd4,
    KIND_JUMP      = 4'd5,
    KIND_FRAME_LEN = 4'd6,
    KIND_DEFINE    = 4'd7,
    KIND_STEP      = 4'd8
  } kind_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_FILL,
    S_MUL1,
    S_MUL2,
    S_ADD,
    S_ADV_CHK,
    S_ADV_WAIT,
    S_ADV_CMP,
    S_OUT_RD,
    S_OUT
  } state_t;

  typedef struct packed {
    logic [KIND_W-1:0]      kind;
    logic [DT_W-1:0]        dt_step;
    logic [ANIM_IDX_W-1:0]  anim_index;
    logic [POS_W-1:0]       position;
    logic [FRAME_IDX_W-1:0] frame_index;
    logic [LEN_VAL_W-1:0]   length_value;
    logic [SPEED_W-1:0]     speed_value;
    logic                   loop_flag;
    logic                   restart_flag;
  } item_t;

  typedef struct packed {
    logic [FRAME_IDX_W-1:0] current_frame;
    logic [POS_W-1:0]       current_position;
    logic                   is_playing;
  } res_t;

  typedef struct packed {
    logic capture;
    logic exec;
    logic len_item;
    logic fill_step;
    logic fill_last;
    logic mul1;
    logic mul2;
    logic add;
    logic adv_cmp;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    kind_t kind;
    logic  playing;
    logic  step_ok;
    logic  fill_done;
    logic  adv_stop;
    logic  adv_more;
    logic  out_free;
  } status_t;

  typedef struct packed {
    logic               en;
    logic [SPEED_W-1:0] data;
  } cfg_wr_t;

endpackage

### src/sas_if.sv
interface sas_feed_if;
  import sas_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [KIND_W-1:0]      kind;
  logic [DT_W-1:0]        dt_step;
  logic [ANIM_IDX_W-1:0]  anim_index;
  logic [POS_W-1:0]       position;
  logic [FRAME_IDX_W-1:0] frame_index;
  logic [LEN_VAL_W-1:0]   length_value;
  logic [SPEED_W-1:0]     speed_value;
  logic                   loop_flag;
  logic                   restart_flag;

  modport source (
    output valid, kind, dt_step, anim_index, position, frame_index,
           length_value, speed_value, loop_flag, restart_flag,
    input  ready
  );

  modport sink (
    input  valid, kind, dt_step, anim_index, position, frame_index,
           length_value, speed_value, loop_flag, restart_flag,
    output ready
  );
endinterface

interface sas_result_if;
  import sas_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [FRAME_IDX_W-1:0] current_frame;
  logic [POS_W-1:0]       current_position;
  logic                   is_playing;

  modport source (
    output valid, current_frame, current_position, is_playing,
    input  ready
  );

  modport sink (
    input  valid, current_frame, current_position, is_playing,
    output ready
  );
endinterface

### src/sprite_animation_sequencer_core.sv
// Plays one sprite animation at a time from a frame-length table, per-animation speeds
// and step sequences, all loaded through input words; every input word returns one
// result word with the shown frame, the sequence position and the playing flag. One
// word is worked on at a time: control words (play, pause, resume, rewind, jump,
// frame length, define) go straight to the result, a step write first fills each
// skipped position with frame 0, and a tick advances frame by frame (at most SEQ_LEN
// advances); each advance reads the step table and then the frame-length table,
// one registered read after the other. A tick while paused advances nothing. The
// next word is accepted while the previous result waits in the output register.
// global_speed sits at byte address 0 of the register port; no clearing pass
// follows reset.
module sprite_animation_sequencer_core #(
  parameter int FRAME_COUNT = sas_pkg::DEF_FRAME_COUNT,
  parameter int ANIM_COUNT  = sas_pkg::DEF_ANIM_COUNT,
  parameter int SEQ_LEN     = sas_pkg::DEF_SEQ_LEN
) (
  input  logic                            clk,
  input  logic                            rst,
  sas_feed_if.sink                        feed,
  sas_result_if.source                    result,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [sas_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [sas_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [sas_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                            pready
);
  import sas_pkg::*;

  cmd_t               cmd;
  status_t            stat;
  item_t              feed_item;
  cfg_wr_t            cfg_wr;
  res_t               out_res;
  logic               in_ready;
  logic               out_valid;
  logic [SPEED_W-1:0] global_speed;
  logic               reg_hit;

  // register port
  assign pready        = 1'b1;
  assign reg_hit       = paddr[CFG_ADDR_W-1:2] == REG_GLOBAL_SPEED;
  assign cfg_wr.en     = psel && penable && pwrite && reg_hit;
  assign cfg_wr.data   = pwdata[SPEED_W-1:0];
  assign prdata        = reg_hit ? CFG_DATA_W'(global_speed) : '0;

  // input word bundle
  assign feed.ready = in_ready;
  always_comb begin
    feed_item.kind         = feed.kind;
    feed_item.dt_step      = feed.dt_step;
    feed_item.anim_index   = feed.anim_index;
    feed_item.position     = feed.position;
    feed_item.frame_index  = feed.frame_index;
    feed_item.length_value = feed.length_value;
    feed_item.speed_value  = feed.speed_value;
    feed_item.loop_flag    = feed.loop_flag;
    feed_item.restart_flag = feed.restart_flag;
  end

  // result word
  assign result.valid            = out_valid;
  assign result.current_frame    = out_res.current_frame;
  assign result.current_position = out_res.current_position;
  assign result.is_playing       = out_res.is_playing;

  sas_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (feed.valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  sas_dpath #(
    .FRAME_COUNT (FRAME_COUNT),
    .ANIM_COUNT  (ANIM_COUNT),
    .SEQ_LEN     (SEQ_LEN)
  ) u_dpath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .feed_item    (feed_item),
    .cfg_wr       (cfg_wr),
    .global_speed (global_speed),
    .out_ready    (result.ready),
    .out_valid    (out_valid),
    .out_res      (out_res)
  );

endmodule

### src/sas_ctrl.sv
module sas_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  sas_pkg::status_t  stat,
  output sas_pkg::cmd_t     cmd
);
  import sas_pkg::*;

  state_t state;
  state_t state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd.exec     = 1'b1;
        cmd.len_item = 1'b1;
        case (stat.kind)
          KIND_TICK: state_next = stat.playing ? S_MUL1 : S_OUT_RD;
          KIND_STEP: state_next = stat.step_ok ? S_FILL : S_OUT_RD;
          default:   state_next = S_OUT_RD;
        endcase
      end
      S_FILL: begin
        cmd.len_item = 1'b1;
        if (stat.fill_done) begin
          cmd.fill_last = 1'b1;
          state_next    = S_OUT_RD;
        end else begin
          cmd.fill_step = 1'b1;
        end
      end
      S_MUL1: begin
        cmd.mul1   = 1'b1;
        state_next = S_MUL2;
      end
      S_MUL2: begin
        cmd.mul2   = 1'b1;
        state_next = S_ADD;
      end
      S_ADD: begin
        cmd.add    = 1'b1;
        state_next = S_ADV_CHK;
      end
      S_ADV_CHK: begin
        state_next = stat.adv_stop ? S_OUT_RD : S_ADV_WAIT;
      end
      S_ADV_WAIT: begin
        state_next = S_ADV_CMP;
      end
      S_ADV_CMP: begin
        cmd.adv_cmp = 1'b1;
        state_next  = stat.adv_more ? S_ADV_CHK : S_OUT_RD;
      end
      S_OUT_RD: begin
        state_next = S_OUT;
      end
      S_OUT: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

### src/sas_dpath.sv
module sas_dpath #(
  parameter int FRAME_COUNT = sas_pkg::DEF_FRAME_COUNT,
  parameter int ANIM_COUNT  = sas_pkg::DEF_ANIM_COUNT,
  parameter int SEQ_LEN     = sas_pkg::DEF_SEQ_LEN
) (
  input  logic                         clk,
  input  logic                         rst,
  input  sas_pkg::cmd_t                cmd,
  output sas_pkg::status_t             stat,
  input  sas_pkg::item_t               feed_item,
  input  sas_pkg::cfg_wr_t             cfg_wr,
  output logic [sas_pkg::SPEED_W-1:0]  global_speed,
  input  logic                         out_ready,
  output logic                         out_valid,
  output sas_pkg::res_t                out_res
);
  import sas_pkg::*;

  // only entries the index fields can reach are stored
  localparam int FRAME_DEPTH = (FRAME_COUNT < (1 << FRAME_IDX_W)) ?
                               FRAME_COUNT : (1 << FRAME_IDX_W);
  localparam int FW          = $clog2(FRAME_DEPTH);
  localparam int ANIM_DEPTH  = (ANIM_COUNT < (1 << ANIM_IDX_W)) ?
                               ANIM_COUNT : (1 << ANIM_IDX_W);
  localparam int AW          = (ANIM_DEPTH > 1) ? $clog2(ANIM_DEPTH) : 1;
  localparam int SEQ_DEPTH   = (SEQ_LEN < (1 << POS_W)) ? SEQ_LEN : (1 << POS_W);
  localparam int PW          = $clog2(SEQ_DEPTH);
  localparam int STEP_DEPTH  = ANIM_DEPTH * (1 << PW);
  localparam int SW          = AW + PW;
  localparam int CNT_W       = $clog2(SEQ_LEN + 1);
  localparam int ADDEND_W    = PROD2_W - FRAC_W;
  localparam int SUM_W       = ADDEND_W + 1;

  // memories
  logic [LEN_VAL_W-1:0]   frame_mem [FRAME_DEPTH];
  logic [SPEED_W-1:0]     speed_mem [ANIM_DEPTH];
  logic [FRAME_IDX_W-1:0] step_mem  [STEP_DEPTH];

  // control state
  logic [LEN_W-1:0]     seq_len [ANIM_DEPTH];
  logic [AW-1:0]        active_anim;
  logic [POS_W-1:0]     active_position;
  logic [ELAPSED_W-1:0] elapsed;
  logic                 playing;
  logic                 looping;
  logic [CNT_W-1:0]     adv_cnt;

  // payload
  item_t                  item;
  logic [PROD1_W-1:0]     m1;
  logic [PROD2_W-1:0]     m2;
  logic [LEN_W-1:0]       fill_ptr;
  logic [SPEED_W-1:0]     speed_q;
  logic [FRAME_IDX_W-1:0] step_q;
  logic [LEN_VAL_W-1:0]   flen_q;
  logic                   frame_oob_q;

  // decode of the held word
  logic             anim_ok;
  logic             frame_ok;
  logic             pos_ok;
  logic             step_ok;
  logic             same_play;
  logic [AW-1:0]    item_anim;
  logic [AW-1:0]    len_addr;
  logic [LEN_W-1:0] len_rd;
  logic [LEN_W-1:0] item_pos_len;

  assign item_anim    = item.anim_index[AW-1:0];
  assign item_pos_len = LEN_W'(item.position);
  assign anim_ok      = 32'(item.anim_index) < ANIM_COUNT;
  assign frame_ok     = 32'(item.frame_index) < FRAME_COUNT;
  assign pos_ok       = 32'(item.position) < SEQ_LEN;
  assign step_ok      = anim_ok && pos_ok;
  assign same_play    = (ANIM_IDX_W'(active_anim) == item.anim_index) && playing &&
                        !item.restart_flag;
  assign len_addr     = cmd.len_item ? item_anim : active_anim;
  assign len_rd       = seq_len[len_addr];

  // tick arithmetic
  logic [ADDEND_W-1:0] addend;
  logic [SUM_W-1:0]    sum;

  assign addend = m2[PROD2_W-1:FRAC_W];
  assign sum    = SUM_W'(elapsed) + SUM_W'(addend);

  // one advance step
  logic [LEN_VAL_W-1:0] flen_eff;
  logic                 fits;
  logic [LEN_W-1:0]     pos_inc;
  logic                 at_end;

  assign flen_eff = frame_oob_q ? '0 : flen_q;
  assign fits     = elapsed >= ELAPSED_W'(flen_eff);
  assign pos_inc  = LEN_W'(active_position) + LEN_W'(1);
  assign at_end   = pos_inc >= len_rd;

  // step memory port
  logic                   step_we;
  logic [SW-1:0]          step_waddr;
  logic [FRAME_IDX_W-1:0] step_wdata;
  logic [SW-1:0]          step_raddr;

  assign step_we    = cmd.fill_step || cmd.fill_last;
  assign step_waddr = cmd.fill_last ? {item_anim, item.position[PW-1:0]} :
                                      {item_anim, fill_ptr[PW-1:0]};
  assign step_wdata = cmd.fill_last ? item.frame_index : '0;
  assign step_raddr = {active_anim, active_position[PW-1:0]};

  // status to the controller
  always_comb begin
    stat.kind      = kind_t'(item.kind);
    stat.playing   = playing;
    stat.step_ok   = step_ok;
    stat.fill_done = !(fill_ptr < item_pos_len);
    stat.adv_stop  = (adv_cnt == CNT_W'(SEQ_LEN)) || (LEN_W'(active_position) >= len_rd);
    stat.adv_more  = fits && !(at_end && !looping);
    stat.out_free  = !out_valid || out_ready;
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      seq_len         <= '{default: '0};
      active_anim     <= '0;
      active_position <= '0;
      elapsed         <= '0;
      playing         <= 1'b0;
      looping         <= 1'b0;
      adv_cnt         <= '0;
      global_speed    <= GLOBAL_SPEED_RESET;
      out_valid       <= 1'b0;
    end else begin
      if (cfg_wr.en) begin
        global_speed <= cfg_wr.data;
      end
      // per-kind updates
      if (cmd.exec) begin
        case (kind_t'(item.kind))
          KIND_PLAY: begin
            if (anim_ok && !same_play) begin
              active_anim     <= item_anim;
              active_position <= item.position;
              playing         <= 1'b1;
              looping         <= item.loop_flag;
            end
          end
          KIND_PAUSE:  playing <= 1'b0;
          KIND_RESUME: playing <= 1'b1;
          KIND_REWIND: active_position <= '0;
          KIND_JUMP:   active_position <= item.position;
          KIND_DEFINE: begin
            if (anim_ok) begin
              seq_len[item_anim] <= '0;
            end
          end
          default: begin
          end
        endcase
      end
      // sequence grows to the written position
      if (cmd.fill_last && (item_pos_len >= len_rd)) begin
        seq_len[item_anim] <= item_pos_len + LEN_W'(1);
      end
      // saturating time add
      if (cmd.add) begin
        elapsed <= (|sum[SUM_W-1:ELAPSED_W]) ? '1 : sum[ELAPSED_W-1:0];
        adv_cnt <= '0;
      end
      // frame advance
      if (cmd.adv_cmp && fits) begin
        elapsed <= elapsed - ELAPSED_W'(flen_eff);
        adv_cnt <= adv_cnt + CNT_W'(1);
        if (at_end) begin
          if (looping) begin
            active_position <= '0;
          end else begin
            playing <= 1'b0;
          end
        end else begin
          active_position <= pos_inc[POS_W-1:0];
        end
      end
      // output word slot
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item <= feed_item;
    end
    if (cmd.exec && (kind_t'(item.kind) == KIND_STEP)) begin
      fill_ptr <= len_rd;
    end else if (cmd.fill_step) begin
      fill_ptr <= fill_ptr + LEN_W'(1);
    end
    if (cmd.mul1) begin
      m1 <= PROD1_W'(global_speed) * PROD1_W'(speed_q);
    end
    if (cmd.mul2) begin
      m2 <= PROD2_W'(item.dt_step) * PROD2_W'(m1);
    end
    if (cmd.out_load) begin
      out_res.current_frame    <= (LEN_W'(active_position) < len_rd) ? step_q : '0;
      out_res.current_position <= active_position;
      out_res.is_playing       <= playing;
    end
  end

  // frame length table
  always_ff @(posedge clk) begin
    if (cmd.exec && (kind_t'(item.kind) == KIND_FRAME_LEN) && frame_ok) begin
      frame_mem[item.frame_index[FW-1:0]] <= item.length_value;
    end
    flen_q      <= frame_mem[step_q[FW-1:0]];
    frame_oob_q <= !(32'(step_q) < FRAME_COUNT);
  end

  // animation speed table
  always_ff @(posedge clk) begin
    if (cmd.exec && (kind_t'(item.kind) == KIND_DEFINE) && anim_ok) begin
      speed_mem[item_anim] <= item.speed_value;
    end
    speed_q <= speed_mem[active_anim];
  end

  // sequence step table
  always_ff @(posedge clk) begin
    if (step_we) begin
      step_mem[step_waddr] <= step_wdata;
    end
    step_q <= step_mem[step_raddr];
  end

`ifndef SYNTHESIS
  // an advance leaves the position inside the sequence
  a_pos_in_seq: assert property (@(posedge clk) disable iff (rst)
    (cmd.adv_cmp && fits) |=> (LEN_W'(active_position) < seq_len[active_anim]))
    else $error("position left the sequence after an advance");

  // advancing only consumes time
  a_elapsed_down: assert property (@(posedge clk) disable iff (rst)
    cmd.adv_cmp |=> (elapsed <= $past(elapsed)))
    else $error("elapsed time grew during an advance");

  // gap fill stays below the written position
  a_fill_below: assert property (@(posedge clk) disable iff (rst)
    cmd.fill_step |-> (fill_ptr < item_pos_len))
    else $error("gap fill ran past the step position");

  // playback stops only on pause or at the end of a one-shot run
  a_play_stop: assert property (@(posedge clk) disable iff (rst)
    ($fell(playing) && $past(!rst)) |->
      $past((cmd.exec && (item.kind == KIND_PAUSE)) || (cmd.adv_cmp && !looping)))
    else $error("playback stopped without cause");
`endif

endmodule
